// File: rtl/core/mcps_pkg.sv
// shared types, codes and constants of the pulse scheduler
`default_nettype none

package mcps_pkg;

   localparam int MCPS_PIN_SLOTS = 8;
   localparam int MCPS_MAX_RESULTS = 8;
   localparam logic [31:0] MCPS_DURATION_LIMIT = 32'h8000_0000;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PULSE = 2'd1;
   localparam logic [1:0] OP_SETUP = 2'd2;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_BAD_PIN      = 2'd1;
   localparam logic [1:0] STATUS_BAD_DURATION = 2'd2;
   localparam logic [1:0] STATUS_BUSY         = 2'd3;

   typedef struct packed {
      logic        enable;
      logic [2:0]  bank;
      logic [31:0] mask;
      logic        idle;
   } slot_cfg_type;

   typedef struct packed {
      logic cfg_we;
      logic dl_we;
      logic busy_set;
      logic busy_clr;
   } slot_ctl_type;

   typedef struct packed {
      slot_cfg_type cfg;
      logic         busy;
      logic [31:0]  deadline;
   } slot_rd_type;

endpackage

`default_nettype wire

// File: rtl/core/mcps_alu.sv
// shared 32-bit add and subtract unit
`default_nettype none

module mcps_alu
   import mcps_pkg::*;
(
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   input  wire logic        sub,
   output logic [31:0]      y
);

   always_comb begin
      y = a + (b ^ {32{sub}}) + {31'd0, sub};
   end

endmodule

`default_nettype wire

// File: rtl/core/mcps_slot_table.sv
// pin slot table: setup words, deadlines and busy flags
`default_nettype none

module mcps_slot_table
   import mcps_pkg::*;
#(
   parameter int PIN_SLOTS = MCPS_PIN_SLOTS,
   localparam int AW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire slot_ctl_type  ctl,
   input  wire logic [AW-1:0] wr_addr,
   input  wire slot_cfg_type  wr_cfg,
   input  wire logic [31:0]   wr_deadline,
   input  wire logic [AW-1:0] rd_addr,
   output slot_rd_type        rd
);

   slot_cfg_type cfg_mem [PIN_SLOTS];
   logic [31:0]  dl_mem  [PIN_SLOTS];

   slot_cfg_type          cfg_q_ff;
   logic [31:0]           dl_q_ff;
   logic [AW-1:0]         rd_addr_ff;
   logic [PIN_SLOTS-1:0]  written_ff, written_in;
   logic [PIN_SLOTS-1:0]  busy_ff, busy_in;

   always_ff @(posedge clock) begin
      if (ctl.cfg_we) begin
         cfg_mem[wr_addr] <= wr_cfg;
      end
      if (ctl.dl_we) begin
         dl_mem[wr_addr] <= wr_deadline;
      end
      cfg_q_ff   <= cfg_mem[rd_addr];
      dl_q_ff    <= dl_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_comb begin
      written_in = written_ff;
      busy_in    = busy_ff;
      if (ctl.cfg_we) begin
         written_in[wr_addr] = 1'b1;
      end
      if (ctl.busy_set) begin
         busy_in[wr_addr] = 1'b1;
      end
      if (ctl.busy_clr) begin
         busy_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         busy_ff    <= '0;
      end else begin
         written_ff <= written_in;
         busy_ff    <= busy_in;
      end
   end

   // never written slot reads as the cleared setup word
   always_comb begin
      rd.cfg      = written_ff[rd_addr_ff] ? cfg_q_ff : '0;
      rd.busy     = busy_ff[rd_addr_ff];
      rd.deadline = dl_q_ff;
   end

endmodule

`default_nettype wire

// File: rtl/core/multi_channel_pulse_scheduler_core.sv
// top level of the multi-channel pulse scheduler: sequencer and result register
//
// channel  direction  handshake           word
// req      in         req_valid/req_stall tick, pulse command or pin slot setup
// rsp      out        rsp_valid/rsp_stall gpio write, status and running totals
//
// a tick walks the slots one per cycle, held while an expiry waits on
// a stalled rsp, through the single slot read port and the shared adder
// that forms time_now - deadline
// synchronous reset clears time, counters, busy flags and slot setup at once
// a stalled rsp holds the sequencer only when a new word must enter it;
// a finished word waits in the result register while the next req is taken
`default_nettype none

module multi_channel_pulse_scheduler_core
   import mcps_pkg::*;
#(
   parameter int PIN_SLOTS = MCPS_PIN_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_pin_id,
   input  wire logic [31:0] req_duration,
   input  wire logic        req_pulse_level,
   input  wire logic [31:0] req_seq,
   input  wire logic        req_pin_enable,
   input  wire logic [2:0]  req_pin_bank,
   input  wire logic [31:0] req_pin_mask,
   input  wire logic        req_rest_level,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_write_valid,
   output logic [1:0]       rsp_gpio_bank,
   output logic [31:0]      rsp_gpio_bits,
   output logic             rsp_gpio_level,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_seq_echo,
   output logic             rsp_last,
   output logic [31:0]      rsp_accepted_total,
   output logic [31:0]      rsp_rejected_total,
   output logic [31:0]      rsp_expired_total
);

   localparam int AW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(PIN_SLOTS - 1);
   localparam int NW = $clog2(MCPS_MAX_RESULTS + 1);
   localparam logic [NW-1:0] N_LAST = NW'(MCPS_MAX_RESULTS - 1);
   localparam logic [NW-1:0] N_MAX  = NW'(MCPS_MAX_RESULTS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_T_INC = 3'd1;
   localparam logic [2:0] S_T_CHK = 3'd2;
   localparam logic [2:0] S_T_END = 3'd3;
   localparam logic [2:0] S_C_CHK = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [NW-1:0] n_ff, n_in;

   // latched command word
   logic [7:0]  pin_ff, pin_in;
   logic [31:0] dur_ff, dur_in;
   logic        act_ff, act_in;
   logic [31:0] seq_ff, seq_in;

   // time and running totals
   logic [31:0] time_ff, time_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] rej_ff, rej_in;
   logic [31:0] exp_ff, exp_in;

   // expiry held back until it is known whether another one follows
   logic        pend_valid_ff, pend_valid_in;
   logic        pend_wv_ff, pend_wv_in;
   logic [1:0]  pend_bank_ff, pend_bank_in;
   logic [31:0] pend_mask_ff, pend_mask_in;
   logic        pend_level_ff, pend_level_in;
   logic [31:0] pend_exp_ff, pend_exp_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_wv_ff, rsp_wv_in;
   logic [1:0]  rsp_bank_ff, rsp_bank_in;
   logic [31:0] rsp_mask_ff, rsp_mask_in;
   logic        rsp_level_ff, rsp_level_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_seq_ff, rsp_seq_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_acc_ff, rsp_acc_in;
   logic [31:0] rsp_rej_ff, rsp_rej_in;
   logic [31:0] rsp_exp_ff, rsp_exp_in;

   // slot table and shared adder hookup
   slot_ctl_type  tbl_ctl;
   logic [AW-1:0] tbl_wr_addr;
   slot_cfg_type  tbl_wr_cfg;
   logic [AW-1:0] tbl_rd_addr;
   slot_rd_type   slot;
   logic [31:0]   alu_b;
   logic          alu_sub;
   logic [31:0]   alu_y;

   logic       req_acc;
   logic       out_free;
   logic       exp_hit;
   logic       scan_done;
   logic       slot_usable;
   logic [1:0] cmd_status;

   mcps_slot_table #(
      .PIN_SLOTS (PIN_SLOTS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (tbl_ctl),
      .wr_addr     (tbl_wr_addr),
      .wr_cfg      (tbl_wr_cfg),
      .wr_deadline (alu_y),
      .rd_addr     (tbl_rd_addr),
      .rd          (slot)
   );

   mcps_alu u_alu (
      .a   (time_ff),
      .b   (alu_b),
      .sub (alu_sub),
      .y   (alu_y)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // one adder: time + 1, time + duration, or time - deadline
   always_comb begin
      alu_sub = (state_ff == S_T_CHK);
      case (state_ff)
         S_T_CHK: alu_b = slot.deadline;
         S_C_CHK: alu_b = dur_ff;
         default: alu_b = 32'd1;
      endcase
   end

   // expired once the wrapped difference is non-negative
   assign exp_hit     = slot.cfg.enable && slot.busy && !alu_y[31];
   assign scan_done   = (idx_ff == LAST_IDX) || (exp_hit && (n_ff == N_LAST));
   assign slot_usable = slot.cfg.enable && (slot.cfg.mask != 32'd0) && !slot.cfg.bank[2];

   // command checks in priority order
   always_comb begin
      if (pin_ff >= 8'(PIN_SLOTS)) begin
         cmd_status = STATUS_BAD_PIN;
      end else if ((dur_ff == 32'd0) || (dur_ff >= MCPS_DURATION_LIMIT)) begin
         cmd_status = STATUS_BAD_DURATION;
      end else if (!slot_usable) begin
         cmd_status = STATUS_BAD_PIN;
      end else if (slot.busy) begin
         cmd_status = STATUS_BUSY;
      end else begin
         cmd_status = STATUS_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      pin_in        = pin_ff;
      dur_in        = dur_ff;
      act_in        = act_ff;
      seq_in        = seq_ff;
      time_in       = time_ff;
      acc_in        = acc_ff;
      rej_in        = rej_ff;
      exp_in        = exp_ff;
      pend_valid_in = pend_valid_ff;
      pend_wv_in    = pend_wv_ff;
      pend_bank_in  = pend_bank_ff;
      pend_mask_in  = pend_mask_ff;
      pend_level_in = pend_level_ff;
      pend_exp_in   = pend_exp_ff;

      // a taken word leaves unless a new one is loaded below
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_wv_in     = rsp_wv_ff;
      rsp_bank_in   = rsp_bank_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_status_in = rsp_status_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_exp_in    = rsp_exp_ff;

      tbl_ctl           = '0;
      tbl_wr_addr       = pin_ff[AW-1:0];
      tbl_wr_cfg.enable = req_pin_enable;
      tbl_wr_cfg.bank   = req_pin_bank;
      tbl_wr_cfg.mask   = req_pin_mask;
      tbl_wr_cfg.idle   = req_rest_level;
      tbl_rd_addr       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            // read the addressed slot now so a command can check it next cycle
            tbl_rd_addr = req_pin_id[AW-1:0];
            tbl_wr_addr = req_pin_id[AW-1:0];
            if (req_acc) begin
               pin_in = req_pin_id;
               dur_in = req_duration;
               act_in = req_pulse_level;
               seq_in = req_seq;
               case (req_op)
                  OP_TICK:  state_in = S_T_INC;
                  OP_PULSE: state_in = S_C_CHK;
                  OP_SETUP: tbl_ctl.cfg_we = (req_pin_id < 8'(PIN_SLOTS));
                  default:  state_in = S_IDLE;
               endcase
            end
         end

         S_T_INC: begin
            time_in     = alu_y;
            idx_in      = '0;
            n_in        = '0;
            tbl_rd_addr = '0;
            state_in    = S_T_CHK;
         end

         S_T_CHK: begin
            // hold on this slot while the held expiry cannot move out
            if (!(exp_hit && pend_valid_ff && !out_free)) begin
               if (exp_hit) begin
                  tbl_wr_addr      = idx_ff;
                  tbl_ctl.busy_clr = 1'b1;
                  exp_in           = exp_ff + 32'd1;
                  n_in             = n_ff + NW'(1);
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_wv_in     = pend_wv_ff;
                     rsp_bank_in   = pend_bank_ff;
                     rsp_mask_in   = pend_mask_ff;
                     rsp_level_in  = pend_level_ff;
                     rsp_status_in = STATUS_OK;
                     rsp_seq_in    = 32'd0;
                     rsp_last_in   = 1'b0;
                     rsp_acc_in    = acc_ff;
                     rsp_rej_in    = rej_ff;
                     rsp_exp_in    = pend_exp_ff;
                  end
                  // invalid bank still expires, but without a write
                  pend_valid_in = 1'b1;
                  pend_wv_in    = !slot.cfg.bank[2];
                  pend_bank_in  = slot.cfg.bank[2] ? 2'd0 : slot.cfg.bank[1:0];
                  pend_mask_in  = slot.cfg.bank[2] ? 32'd0 : slot.cfg.mask;
                  pend_level_in = slot.cfg.idle && !slot.cfg.bank[2];
                  pend_exp_in   = exp_ff + 32'd1;
               end
               if (scan_done) begin
                  state_in = S_T_END;
               end else begin
                  idx_in      = idx_ff + AW'(1);
                  tbl_rd_addr = idx_ff + AW'(1);
               end
            end
         end

         S_T_END: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_wv_in     = pend_wv_ff;
               rsp_bank_in   = pend_bank_ff;
               rsp_mask_in   = pend_mask_ff;
               rsp_level_in  = pend_level_ff;
               rsp_status_in = STATUS_OK;
               rsp_seq_in    = 32'd0;
               rsp_last_in   = 1'b1;
               rsp_acc_in    = acc_ff;
               rsp_rej_in    = rej_ff;
               rsp_exp_in    = pend_exp_ff;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_C_CHK: begin
            tbl_rd_addr = pin_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cmd_status;
               rsp_seq_in    = seq_ff;
               rsp_last_in   = 1'b1;
               rsp_exp_in    = exp_ff;
               if (cmd_status == STATUS_OK) begin
                  tbl_ctl.busy_set = 1'b1;
                  tbl_ctl.dl_we    = 1'b1;
                  acc_in           = acc_ff + 32'd1;
                  rsp_wv_in        = 1'b1;
                  rsp_bank_in      = slot.cfg.bank[1:0];
                  rsp_mask_in      = slot.cfg.mask;
                  rsp_level_in     = act_ff;
                  rsp_acc_in       = acc_ff + 32'd1;
                  rsp_rej_in       = rej_ff;
               end else begin
                  rej_in       = rej_ff + 32'd1;
                  rsp_wv_in    = 1'b0;
                  rsp_bank_in  = 2'd0;
                  rsp_mask_in  = 32'd0;
                  rsp_level_in = 1'b0;
                  rsp_acc_in   = acc_ff;
                  rsp_rej_in   = rej_ff + 32'd1;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         n_ff          <= '0;
         time_ff       <= 32'd0;
         acc_ff        <= 32'd0;
         rej_ff        <= 32'd0;
         exp_ff        <= 32'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         time_ff       <= time_in;
         acc_ff        <= acc_in;
         rej_ff        <= rej_in;
         exp_ff        <= exp_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pin_ff        <= pin_in;
      dur_ff        <= dur_in;
      act_ff        <= act_in;
      seq_ff        <= seq_in;
      pend_wv_ff    <= pend_wv_in;
      pend_bank_ff  <= pend_bank_in;
      pend_mask_ff  <= pend_mask_in;
      pend_level_ff <= pend_level_in;
      pend_exp_ff   <= pend_exp_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_bank_ff   <= rsp_bank_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_exp_ff    <= rsp_exp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_valid    = rsp_wv_ff;
   assign rsp_gpio_bank      = rsp_bank_ff;
   assign rsp_gpio_bits      = rsp_mask_ff;
   assign rsp_gpio_level     = rsp_level_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_seq_echo       = rsp_seq_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_accepted_total = rsp_acc_ff;
   assign rsp_rejected_total = rsp_rej_ff;
   assign rsp_expired_total  = rsp_exp_ff;

`ifndef SYNTHESIS
   // a held expiry is always drained before a new word is taken
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("expiry still held while idle");

   // a word that is not last always has a successor waiting
   a_not_last_has_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> pend_valid_ff)
      else $error("non-last word without a following expiry");

   // the scan never checks a slot after the expiry limit is reached
   a_scan_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T_CHK) |-> (n_ff < N_MAX))
      else $error("expiry count past limit during scan");

   // the expiry total only moves out of a slot check
   a_exp_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (exp_ff != $past(exp_ff))) |-> ($past(state_ff) == S_T_CHK))
      else $error("expired total changed outside a slot check");
`endif

endmodule

`default_nettype wire

// File: dv/tb_multi_channel_pulse_scheduler_core.sv
// self-checking testbench of the pulse scheduler core: directed word table, then random traffic
module tb_multi_channel_pulse_scheduler_core;
   import mcps_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SLOTS = MCPS_PIN_SLOTS;
   localparam int SCRIPT_ROWS = 28;
   localparam int RANDOM_WORDS = 210;
   localparam int DRAIN_POINT = 120;
   localparam int QUIET_POINT = 175;
   // settle time covers a tick walking every slot plus the sequencer's overhead states
   localparam int SETTLE_CYCLES = 4 * (SLOTS + 3);

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  pin_id;
      logic [31:0] duration;
      logic        pulse_level;
      logic [31:0] seq;
      logic        pin_enable;
      logic [2:0]  pin_bank;
      logic [31:0] pin_mask;
      logic        rest_level;
   } req_word_type;

   typedef struct packed {
      logic        write_valid;
      logic [1:0]  gpio_bank;
      logic [31:0] gpio_bits;
      logic        gpio_level;
      logic [1:0]  status;
      logic [31:0] seq_echo;
      logic        last;
      logic [31:0] accepted_total;
      logic [31:0] rejected_total;
      logic [31:0] expired_total;
   } gpio_word_type;

   // a directed row, with the status and write flag typed in for pulse commands
   typedef struct packed {
      req_word_type word;
      logic         pinned;
      logic [1:0]   pin_status;
      logic         pin_write;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_TICK;
   logic [7:0]  req_pin_id = '0;
   logic [31:0] req_duration = '0;
   logic        req_pulse_level = 1'b0;
   logic [31:0] req_seq = '0;
   logic        req_pin_enable = 1'b0;
   logic [2:0]  req_pin_bank = '0;
   logic [31:0] req_pin_mask = '0;
   logic        req_rest_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_write_valid;
   logic [1:0]  rsp_gpio_bank;
   logic [31:0] rsp_gpio_bits;
   logic        rsp_gpio_level;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_seq_echo;
   logic        rsp_last;
   logic [31:0] rsp_accepted_total;
   logic [31:0] rsp_rejected_total;
   logic [31:0] rsp_expired_total;

   multi_channel_pulse_scheduler_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_pin_id         (req_pin_id),
      .req_duration       (req_duration),
      .req_pulse_level    (req_pulse_level),
      .req_seq            (req_seq),
      .req_pin_enable     (req_pin_enable),
      .req_pin_bank       (req_pin_bank),
      .req_pin_mask       (req_pin_mask),
      .req_rest_level     (req_rest_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_gpio_bank      (rsp_gpio_bank),
      .rsp_gpio_bits      (rsp_gpio_bits),
      .rsp_gpio_level     (rsp_gpio_level),
      .rsp_status         (rsp_status),
      .rsp_seq_echo       (rsp_seq_echo),
      .rsp_last           (rsp_last),
      .rsp_accepted_total (rsp_accepted_total),
      .rsp_rejected_total (rsp_rejected_total),
      .rsp_expired_total  (rsp_expired_total)
   );

   always #5 clock = ~clock;

   // shadow slot table, mirrors the block's state after reset
   logic [31:0] sched_time = '0;
   logic        slot_on       [SLOTS];
   logic [2:0]  slot_bank     [SLOTS];
   logic [31:0] slot_mask     [SLOTS];
   logic        slot_idle     [SLOTS];
   logic        slot_busy     [SLOTS];
   logic [31:0] slot_deadline [SLOTS];
   logic [31:0] n_accepted = '0;
   logic [31:0] n_rejected = '0;
   logic [31:0] n_expired = '0;

   // gpio words still owed by the block, oldest first
   gpio_word_type gpio_q[$];

   int error_count = 0;
   int results_seen = 0;
   int tick_words = 0;
   int pulse_words = 0;
   int setup_words = 0;
   int peak_burst = 0;
   logic quiet_tail = 1'b0;
   int unsigned stall_run = 0;

   script_row_type script [SCRIPT_ROWS];

   // walk the shadow table for one accepted word and queue the gpio words it causes
   function automatic void advance_slot_table(input req_word_type w, input logic pinned,
                                              input logic [1:0] pin_status,
                                              input logic pin_write);
      gpio_word_type burst [MCPS_MAX_RESULTS];
      gpio_word_type g;
      logic [31:0] lag;
      int n;
      int s;
      int k;
      n = 0;
      case (w.op)
         OP_TICK: begin
            sched_time = sched_time + 32'd1;
            for (s = 0; s < SLOTS && n < MCPS_MAX_RESULTS; s++) begin
               lag = sched_time - slot_deadline[s];
               // a disabled slot stays busy until it is enabled again
               if (slot_on[s] && slot_busy[s] && !lag[31]) begin
                  slot_busy[s] = 1'b0;
                  n_expired = n_expired + 32'd1;
                  g = '0;
                  // a bank made invalid mid-pulse still expires, but without a write
                  g.write_valid = (slot_bank[s] <= 3'd3);
                  if (g.write_valid) begin
                     g.gpio_bank = slot_bank[s][1:0];
                     g.gpio_bits = slot_mask[s];
                     g.gpio_level = slot_idle[s];
                  end
                  g.status = STATUS_OK;
                  g.accepted_total = n_accepted;
                  g.rejected_total = n_rejected;
                  g.expired_total = n_expired;
                  burst[n] = g;
                  n++;
               end
            end
            if (n > peak_burst) peak_burst = n;
         end
         OP_PULSE: begin
            g = '0;
            s = int'(w.pin_id);
            g.status = STATUS_OK;
            // checks run in priority order: pin range, duration, usable slot, busy
            if (w.pin_id >= SLOTS) begin
               g.status = STATUS_BAD_PIN;
            end else if (w.duration == '0 || w.duration >= MCPS_DURATION_LIMIT) begin
               g.status = STATUS_BAD_DURATION;
            end else if (!slot_on[s] || slot_mask[s] == '0 || slot_bank[s] > 3'd3) begin
               g.status = STATUS_BAD_PIN;
            end else if (slot_busy[s]) begin
               g.status = STATUS_BUSY;
            end else begin
               slot_busy[s] = 1'b1;
               slot_deadline[s] = sched_time + w.duration;
               n_accepted = n_accepted + 32'd1;
               g.write_valid = 1'b1;
               g.gpio_bank = slot_bank[s][1:0];
               g.gpio_bits = slot_mask[s];
               g.gpio_level = w.pulse_level;
            end
            if (g.status != STATUS_OK) n_rejected = n_rejected + 32'd1;
            // typed-in table values take the place of the computed ones
            if (pinned) begin
               g.status = pin_status;
               g.write_valid = pin_write;
               if (!pin_write) begin
                  g.gpio_bank = '0;
                  g.gpio_bits = '0;
                  g.gpio_level = 1'b0;
               end
            end
            g.seq_echo = w.seq;
            g.accepted_total = n_accepted;
            g.rejected_total = n_rejected;
            g.expired_total = n_expired;
            burst[0] = g;
            n = 1;
         end
         OP_SETUP: begin
            // setup leaves busy and deadline alone, out-of-range pins are dropped
            if (w.pin_id < SLOTS) begin
               s = int'(w.pin_id);
               slot_on[s] = w.pin_enable;
               slot_bank[s] = w.pin_bank;
               slot_mask[s] = w.pin_mask;
               slot_idle[s] = w.rest_level;
            end
         end
         default: begin
         end
      endcase
      for (k = 0; k < n; k++) begin
         burst[k].last = (k == n - 1);
         gpio_q.push_back(burst[k]);
      end
   endfunction

   function automatic script_row_type tick_row();
      script_row_type row;
      row = '0;
      row.word.op = OP_TICK;
      return row;
   endfunction

   function automatic script_row_type setup_row(input logic [7:0] pin, input logic en,
                                                input logic [2:0] bank,
                                                input logic [31:0] mask,
                                                input logic idle);
      script_row_type row;
      row = '0;
      row.word.op = OP_SETUP;
      row.word.pin_id = pin;
      row.word.pin_enable = en;
      row.word.pin_bank = bank;
      row.word.pin_mask = mask;
      row.word.rest_level = idle;
      return row;
   endfunction

   function automatic script_row_type pulse_row(input logic [7:0] pin,
                                                input logic [31:0] dur,
                                                input logic act, input logic [31:0] seq,
                                                input logic [1:0] status, input logic wv);
      script_row_type row;
      row = '0;
      row.word.op = OP_PULSE;
      row.word.pin_id = pin;
      row.word.duration = dur;
      row.word.pulse_level = act;
      row.word.seq = seq;
      row.pinned = 1'b1;
      row.pin_status = status;
      row.pin_write = wv;
      return row;
   endfunction

   // random traffic: mostly ticks and pulses on configured slots, some noise
   function automatic req_word_type draw_word();
      req_word_type w;
      int pick;
      w.pin_id = 8'($urandom);
      w.duration = $urandom;
      w.pulse_level = 1'($urandom);
      w.seq = $urandom;
      w.pin_enable = 1'($urandom);
      w.pin_bank = 3'($urandom);
      w.pin_mask = $urandom;
      w.rest_level = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         w.op = OP_UNUSED;
      end else if (pick < 20) begin
         w.op = OP_SETUP;
         if ($urandom_range(0, 19) != 0) w.pin_id = 8'($urandom_range(0, SLOTS - 1));
         w.pin_enable = ($urandom_range(0, 6) != 0);
         if ($urandom_range(0, 6) != 0) w.pin_bank = 3'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0: w.pin_mask = '0;
            1: w.pin_mask = 32'h1 << $urandom_range(0, 31);
            default: begin
            end
         endcase
      end else if (pick < 55) begin
         w.op = OP_PULSE;
         if ($urandom_range(0, 9) != 0) w.pin_id = 8'($urandom_range(0, SLOTS - 1));
         pick = $urandom_range(0, 99);
         if (pick < 75) w.duration = $urandom_range(1, 24);
         else if (pick < 83) w.duration = '0;
         else if (pick < 93) w.duration = MCPS_DURATION_LIMIT | $urandom;
         else w.duration = $urandom_range(25, 400);
      end else begin
         w.op = OP_TICK;
      end
      return w;
   endfunction

   task automatic log_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch on %s at result %0d: expected %h, got %h",
                  what, results_seen, want, got);
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) log_mismatch(what, want, got);
   endtask

   // present one word and hold it until the block takes it
   task automatic push_word(input req_word_type w, input logic pinned,
                            input logic [1:0] pin_status, input logic pin_write);
      req_valid <= 1'b1;
      req_op <= w.op;
      req_pin_id <= w.pin_id;
      req_duration <= w.duration;
      req_pulse_level <= w.pulse_level;
      req_seq <= w.seq;
      req_pin_enable <= w.pin_enable;
      req_pin_bank <= w.pin_bank;
      req_pin_mask <= w.pin_mask;
      req_rest_level <= w.rest_level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (w.op)
         OP_TICK: tick_words++;
         OP_PULSE: pulse_words++;
         OP_SETUP: setup_words++;
         default: begin
         end
      endcase
      advance_slot_table(w, pinned, pin_status, pin_write);
   endtask

   task automatic rest(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold the sender until every owed gpio word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (gpio_q.size() != 0);
   endtask

   // receiver back-pressure: random stall bursts between free runs
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 99) < 35) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 39);
      end
   end

   // every taken rsp word is matched against the oldest owed one
   always @(posedge clock) begin : rsp_check
      gpio_word_type seen;
      gpio_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_write_valid, rsp_gpio_bank, rsp_gpio_bits, rsp_gpio_level, rsp_status,
                 rsp_seq_echo, rsp_last, rsp_accepted_total, rsp_rejected_total,
                 rsp_expired_total};
         results_seen++;
         if (gpio_q.size() == 0) begin
            log_mismatch("unexpected word, seq_echo", '0, seen.seq_echo);
         end else begin
            want = gpio_q.pop_front();
            compare_field("write_valid", 32'(want.write_valid), 32'(seen.write_valid));
            compare_field("gpio_bank", 32'(want.gpio_bank), 32'(seen.gpio_bank));
            compare_field("gpio_bits", want.gpio_bits, seen.gpio_bits);
            compare_field("gpio_level", 32'(want.gpio_level), 32'(seen.gpio_level));
            compare_field("status", 32'(want.status), 32'(seen.status));
            compare_field("seq_echo", want.seq_echo, seen.seq_echo);
            compare_field("last", 32'(want.last), 32'(seen.last));
            compare_field("accepted_total", want.accepted_total, seen.accepted_total);
            compare_field("rejected_total", want.rejected_total, seen.rejected_total);
            compare_field("expired_total", want.expired_total, seen.expired_total);
         end
      end
   end

   initial begin : stimulus
      int r;
      int counted;
      logic drained_mid;
      req_word_type w;
      for (r = 0; r < SLOTS; r++) begin
         slot_on[r] = 1'b0;
         slot_bank[r] = '0;
         slot_mask[r] = '0;
         slot_idle[r] = 1'b0;
         slot_busy[r] = 1'b0;
         slot_deadline[r] = '0;
      end

      // nothing busy right after reset, every slot disabled
      script[0]  = tick_row();
      script[1]  = pulse_row(8'd0, 32'd5, 1'b1, 32'h0, STATUS_BAD_PIN, 1'b0);
      // pin range is checked before the zero duration
      script[2]  = pulse_row(8'd255, 32'd0, 1'b0, 32'hFFFF_FFFF, STATUS_BAD_PIN, 1'b0);
      script[3]  = setup_row(8'd255, 1'b1, 3'd0, 32'hFFFF_FFFF, 1'b1);
      script[4]  = setup_row(8'd0, 1'b1, 3'd3, 32'hFFFF_FFFF, 1'b1);
      script[5]  = pulse_row(8'd0, 32'd0, 1'b1, 32'd1, STATUS_BAD_DURATION, 1'b0);
      script[6]  = pulse_row(8'd0, MCPS_DURATION_LIMIT, 1'b1, 32'd2, STATUS_BAD_DURATION, 1'b0);
      script[7]  = pulse_row(8'd0, 32'd1, 1'b0, 32'hFFFF_FFFF, STATUS_OK, 1'b1);
      script[8]  = pulse_row(8'd0, 32'd3, 1'b1, 32'd3, STATUS_BUSY, 1'b0);
      script[9]  = tick_row();
      // disabled slot, invalid bank and zero mask all read as a bad pin
      script[10] = setup_row(8'd1, 1'b0, 3'd0, 32'h1, 1'b0);
      script[11] = pulse_row(8'd1, 32'd1, 1'b1, 32'd4, STATUS_BAD_PIN, 1'b0);
      script[12] = setup_row(8'd2, 1'b1, 3'd4, 32'h1, 1'b0);
      script[13] = pulse_row(8'd2, 32'd2, 1'b1, 32'd5, STATUS_BAD_PIN, 1'b0);
      script[14] = setup_row(8'd3, 1'b1, 3'd1, 32'h0, 1'b0);
      script[15] = pulse_row(8'd3, 32'd1, 1'b1, 32'd6, STATUS_BAD_PIN, 1'b0);
      // longest legal pulse, this slot stays busy for the rest of the run
      script[16] = setup_row(8'd3, 1'b1, 3'd2, 32'h8000_0000, 1'b0);
      script[17] = pulse_row(8'd3, MCPS_DURATION_LIMIT - 32'd1, 1'b1, 32'd7, STATUS_OK, 1'b1);
      // bank turned invalid while the pulse runs
      script[18] = setup_row(8'd4, 1'b1, 3'd0, 32'h1, 1'b1);
      script[19] = pulse_row(8'd4, 32'd1, 1'b0, 32'd8, STATUS_OK, 1'b1);
      script[20] = setup_row(8'd4, 1'b1, 3'd5, 32'h1, 1'b1);
      // slot disabled while busy, expires only once enabled again
      script[21] = setup_row(8'd7, 1'b1, 3'd1, 32'hF0F0_F0F0, 1'b1);
      script[22] = pulse_row(8'd7, 32'd1, 1'b0, 32'd9, STATUS_OK, 1'b1);
      script[23] = setup_row(8'd7, 1'b0, 3'd1, 32'hF0F0_F0F0, 1'b1);
      script[24] = tick_row();
      script[25] = setup_row(8'd7, 1'b1, 3'd1, 32'hF0F0_F0F0, 1'b1);
      script[26] = tick_row();
      // the unused opcode is swallowed without a word back
      script[27] = tick_row();
      script[27].word.op = OP_UNUSED;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < SCRIPT_ROWS; r++) begin
         push_word(script[r].word, script[r].pinned, script[r].pin_status, script[r].pin_write);
         if ($urandom_range(0, 2) == 0) rest($urandom_range(1, 19));
      end
      drain();

      counted = 0;
      drained_mid = 1'b0;
      while (counted < RANDOM_WORDS) begin
         w = draw_word();
         push_word(w, 1'b0, STATUS_OK, 1'b0);
         if (w.op != OP_UNUSED) counted++;
         if (!drained_mid && counted >= DRAIN_POINT) begin
            drain();
            drained_mid = 1'b1;
         end
         // tail runs flat out on both sides; a back-to-back stretch sits mid-run too
         if (counted >= QUIET_POINT) quiet_tail <= 1'b1;
         else if ((counted < 60 || counted >= 100) && $urandom_range(0, 3) == 0)
            rest($urandom_range(1, 19));
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d ticks, %0d pulse commands, %0d setups; %0d words checked",
               tick_words, pulse_words, setup_words, results_seen);
      $display("pulses accepted %0d, rejected %0d, expired %0d; most expiries in one tick %0d",
               n_accepted, n_rejected, n_expired, peak_burst);
      if (error_count == 0) begin
         $display("tb_multi_channel_pulse_scheduler_core: clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_multi_channel_pulse_scheduler_core: errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("timeout with %0d words still owed", gpio_q.size());
      $display("tb_multi_channel_pulse_scheduler_core: errors");
      $finish;
   end

endmodule
